// ----- design/stable_merge_sorter_core_defines.svh -----
// assertion macros shared by the merge sorter rtl
// no dependencies; expects clk and rst_n in the including scope
`ifndef STABLE_MERGE_SORTER_CORE_DEFINES_SVH
`define STABLE_MERGE_SORTER_CORE_DEFINES_SVH

// same-cycle implication
`define SSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ssc_pkg.sv -----
// shared constants and types for the merge sorter core
// no dependencies
package ssc_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int DATA_W    = 32;
  localparam int IO_W      = 32;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } ssc_state_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } ssc_cmd_t;

  typedef struct packed {
    logic              valid;
    logic              keep;
    logic [DATA_W-1:0] value;
  } ssc_link_t;

endpackage

// ----- design/ssc_cell.sv -----
// one sorting cell: holds one element, inserts in order, shifts down on pop
// depends on ssc_pkg
module ssc_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ssc_pkg::ssc_cmd_t         cmd,
  input  logic [ssc_pkg::DATA_W-1:0] new_value,
  input  ssc_pkg::ssc_link_t        prev_link,
  input  ssc_pkg::ssc_link_t        next_link,
  output ssc_pkg::ssc_link_t        link
);
  import ssc_pkg::*;

  logic              valid_r, valid_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;
  logic              keep;

  // equal keys stay ahead of the new element
  assign keep = valid_r && ($signed(value_r) <= $signed(new_value));

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (cmd.pop) begin
      valid_nxt = next_link.valid;
      value_nxt = next_link.value;
    end else if (cmd.insert && !keep) begin
      if (prev_link.keep) begin
        valid_nxt = 1'b1;
        value_nxt = new_value;
      end else begin
        valid_nxt = prev_link.valid;
        value_nxt = prev_link.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign link.valid = valid_r;
  assign link.keep  = keep;
  assign link.value = value_r;

endmodule

// ----- design/ssc_ctrl.sv -----
// frame control: load and drain sequencing, item and result counters
// depends on ssc_pkg and stable_merge_sorter_core_defines.svh
`include "stable_merge_sorter_core_defines.svh"

module ssc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last_item,
  input  logic              out_ready,
  output logic              in_ready,
  output logic              out_valid,
  output logic              out_last_result,
  output logic              out_overflow,
  output ssc_pkg::ssc_cmd_t cmd
);
  import ssc_pkg::*;

  ssc_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             ovf_r, ovf_nxt;
  logic             in_xfer, out_xfer, full;

  assign full     = (count_r == CNT_W'(MAX_ITEMS));
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_xfer && in_last_item) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_xfer && rem_r == CNT_W'(1)) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd.insert = 1'b0;
    cmd.pop    = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready   = 1'b1;
        cmd.insert = in_valid && !full;
      end
      ST_DRAIN: begin
        out_valid = 1'b1;
        cmd.pop   = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign out_last_result = (rem_r == CNT_W'(1));
  assign out_overflow    = ovf_r;

  always_comb begin
    count_nxt = count_r;
    rem_nxt   = rem_r;
    ovf_nxt   = ovf_r;
    if (in_xfer) begin
      if (!full) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
      if (in_last_item) begin
        rem_nxt = full ? count_r : count_r + CNT_W'(1);
      end
    end
    if (out_xfer) begin
      rem_nxt = rem_r - CNT_W'(1);
      if (rem_r == CNT_W'(1)) begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      rem_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  `SSC_ASSERT_NOW(a_count_max, 1'b1, count_r <= CNT_W'(MAX_ITEMS), "item count above capacity")
  `SSC_ASSERT_NOW(a_drain_nonempty, state_r == ST_DRAIN, rem_r != '0, "draining with nothing left")
  `SSC_ASSERT_NOW(a_cmd_excl, cmd.insert, !cmd.pop, "insert and pop in the same cycle")
  `SSC_ASSERT_NEXT(a_frame_done, out_xfer && rem_r == CNT_W'(1), state_r == ST_LOAD && count_r == '0 && !ovf_r, "frame not closed after final transfer")

endmodule

// ----- design/stable_merge_sorter_core.sv -----
// Stable sorter built from a row of MAX_ITEMS insertion cells.
// Load: one item per cycle, inserted in order as it arrives; items past MAX_ITEMS are dropped and set out_overflow.
// Drain: first result valid the cycle after the last_item transfer, then one per cycle while out_ready is high.
// Reset (rst_n, synchronous) empties all cells and clears counters and the overflow flag.
module stable_merge_sorter_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [ssc_pkg::IO_W-1:0] in_value,
  input  logic                     in_last_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [ssc_pkg::IO_W-1:0] out_sorted_value,
  output logic                     out_last_result,
  output logic                     out_overflow
);
  import ssc_pkg::*;

  ssc_cmd_t          cmd;
  ssc_link_t         lk      [MAX_ITEMS];
  ssc_link_t         prev_lk [MAX_ITEMS];
  ssc_link_t         next_lk [MAX_ITEMS];
  logic [DATA_W-1:0] new_value;
  logic signed [DATA_W-1:0] head_value;

  assign new_value = DATA_W'(in_value);

  ssc_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_last_item    (in_last_item),
    .out_ready       (out_ready),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_last_result (out_last_result),
    .out_overflow    (out_overflow),
    .cmd             (cmd)
  );

  for (genvar gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
    if (gi == 0) begin : g_head
      assign prev_lk[gi] = '{valid: 1'b1, keep: 1'b1, value: '0};
    end else begin : g_mid
      assign prev_lk[gi] = lk[gi-1];
    end
    if (gi == MAX_ITEMS - 1) begin : g_tail
      assign next_lk[gi] = '{valid: 1'b0, keep: 1'b0, value: '0};
    end else begin : g_body
      assign next_lk[gi] = lk[gi+1];
    end

    ssc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .new_value (new_value),
      .prev_link (prev_lk[gi]),
      .next_link (next_lk[gi]),
      .link      (lk[gi])
    );
  end

  assign head_value       = lk[0].value;
  assign out_sorted_value = IO_W'(head_value);

endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench for stable_merge_sorter_core: frames of signed values go in,
// sorted values come out and are checked against a sorted copy kept by the scoreboard
// depends on ssc_pkg and the stable_merge_sorter_core rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IO_W        = ssc_pkg::IO_W;
  localparam int FRAME_CAP   = ssc_pkg::MAX_ITEMS;
  localparam int RANDOM_ITEMS = 72;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 200;
  localparam int LIMIT       = 200000;

  typedef enum int {
    MIX_WIDE,
    MIX_DUPS,
    MIX_EDGES
  } value_mix_t;

  typedef struct {
    logic signed [IO_W-1:0] value;
    logic                   last;
    logic                   overflow;
  } sorted_item_t;

  class sort_scoreboard;
    logic signed [IO_W-1:0] frame_vals[$];
    bit                     frame_dropped;
    sorted_item_t           pending[$];
    int                     errors;

    function new();
      frame_dropped = 1'b0;
      errors = 0;
    endfunction

    // stores the element or marks the frame as overflowed; on the closing
    // transfer the frame is sorted (stable insertion) into expected results
    function void note_input(logic signed [IO_W-1:0] v, logic last);
      logic signed [IO_W-1:0] ordered[$];
      logic signed [IO_W-1:0] key;
      sorted_item_t           item;
      int                     i;
      int                     j;
      if (frame_vals.size() < FRAME_CAP) frame_vals = {frame_vals, v};
      else frame_dropped = 1'b1;
      if (!last) return;
      ordered = frame_vals;
      for (i = 1; i < ordered.size(); i++) begin
        key = ordered[i];
        j = i - 1;
        while (j >= 0 && ordered[j] > key) begin
          ordered[j + 1] = ordered[j];
          j--;
        end
        ordered[j + 1] = key;
      end
      for (i = 0; i < ordered.size(); i++) begin
        item.value    = ordered[i];
        item.last     = (i == ordered.size() - 1);
        item.overflow = frame_dropped;
        pending = {pending, item};
      end
      frame_vals.delete();
      frame_dropped = 1'b0;
    endfunction

    function void check_result(logic signed [IO_W-1:0] v, logic last, logic ovf);
      sorted_item_t exp_item;
      if (pending.size() == 0) begin
        $error("unexpected result transfer: sorted_value %0d", v);
        errors++;
        return;
      end
      exp_item = pending.pop_front();
      if (v !== exp_item.value) begin
        $error("sorted_value expected %0d actual %0d", exp_item.value, v);
        errors++;
      end
      if (last !== exp_item.last) begin
        $error("last_result expected %0b actual %0b", exp_item.last, last);
        errors++;
      end
      if (ovf !== exp_item.overflow) begin
        $error("overflow expected %0b actual %0b", exp_item.overflow, ovf);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic signed [IO_W-1:0] in_value;
  logic                   in_last_item;
  logic                   out_valid;
  logic                   out_ready;
  logic signed [IO_W-1:0] out_sorted_value;
  logic                   out_last_result;
  logic                   out_overflow;

  sort_scoreboard sb;
  int             send_idle;
  int             recv_idle;
  bit             hold_req;
  int             cycle_count;

  stable_merge_sorter_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_last_item     (in_last_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sorted_value (out_sorted_value),
    .out_last_result  (out_last_result),
    .out_overflow     (out_overflow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_list(input logic signed [IO_W-1:0] vals[$]);
    int i;
    for (i = 0; i < vals.size(); i++) begin
      while ($urandom_range(0, 99) < send_idle) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid     <= 1'b1;
      in_value     <= vals[i];
      in_last_item <= (i == vals.size() - 1);
      do @(posedge clk); while (!in_ready);
      sb.note_input(vals[i], i == vals.size() - 1);
      @(negedge clk);
    end
  endtask

  task automatic send_frame(input int len, input value_mix_t mix);
    logic signed [IO_W-1:0] vals[$];
    logic signed [IO_W-1:0] v;
    int                     i;
    for (i = 0; i < len; i++) begin
      case (mix)
        MIX_DUPS: begin
          v = $urandom_range(0, 7);
          v = v - 4;
        end
        MIX_EDGES: begin
          case ($urandom_range(0, 4))
            0: v = 32'sh8000_0000 + $urandom_range(0, 2);
            1: v = 32'sh7fff_ffff - $urandom_range(0, 2);
            2: v = '0;
            3: v = '1;
            default: v = $urandom;
          endcase
        end
        default: v = $urandom;
      endcase
      vals = {vals, v};
    end
    send_list(vals);
  endtask

  // sender pauses until every expected result has been seen
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  initial begin : receiver
    int k;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_sorted_value, out_last_result, out_overflow);
  end

  initial begin : watchdog
    for (cycle_count = 0; cycle_count < LIMIT; cycle_count++) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic signed [IO_W-1:0] vals[$];
    int                     phase;
    int                     sent;
    int                     len;
    int                     pick;
    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_value     = '0;
    in_last_item = 1'b0;
    send_idle    = 0;
    recv_idle    = 0;
    hold_req     = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-element frame
    vals = {32'sh8000_0000};
    send_list(vals);
    // extremes of the value range
    vals = {32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1,
            32'sh7fff_ffff, 32'sh8000_0000};
    send_list(vals);
    // equal keys, then a frame already in ascending order
    vals = {32'sd5, 32'sd5, -32'sd3, 32'sd5, -32'sd3, 32'sd2};
    send_list(vals);
    vals = {-32'sd2, -32'sd1, 32'sd0, 32'sd1};
    send_list(vals);
    // full frame with a dropped closing transfer while the receiver holds off,
    // next frame offered meanwhile
    hold_req = 1'b1;
    send_frame(FRAME_CAP + 1, MIX_EDGES);
    send_frame(5, MIX_DUPS);
    wait_drained();

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 10;
          recv_idle = 59;
        end
        1: begin
          send_idle = 59;
          recv_idle = 10;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      sent = 0;
      while (sent < RANDOM_ITEMS / 3) begin
        pick = $urandom_range(0, 99);
        if (pick < 85) len = $urandom_range(1, 12);
        else if (pick < 93) len = $urandom_range(13, FRAME_CAP - 1);
        else if (pick < 97) len = FRAME_CAP;
        else len = $urandom_range(FRAME_CAP + 1, FRAME_CAP + 6);
        send_frame(len, value_mix_t'($urandom_range(0, 2)));
        sent += len;
      end
      wait_drained();
    end

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
